/* src/lpp_pkg.sv */
// Shared types and constants of the lidar point projection block.
package lpp_pkg;

  // Number of 64-bit matrix registers, the register index width and the address width.
  localparam int NUM_REGS    = 6;
  localparam int REG_IDX_W   = 3;
  localparam int ADDR_W      = 6;

  // Filter limits on raw Q8.8 coordinates and Q0.16 reflectance.
  localparam int X_MAX_RAW    = 6400;
  localparam int Y_MAX_RAW    = 1536;
  localparam int Z_MIN_RAW    = -358;
  localparam int REFL_MIN_RAW = 656;
  localparam int MID_RAW      = 5120;

  // Color arithmetic: |x-20| fits in 13 bits for a kept point.
  localparam int DIFF_W       = 13;
  // 65536/5120 = 64/5; 64 * ceil(2^24/5) >> 24 equals diff * 3355444 >> 18.
  localparam int DEPTH_MUL    = 3355444;
  localparam int DEPTH_SHIFT  = 18;
  // 255/5120 = 51/1024.
  localparam int LEVEL_MUL    = 51;
  localparam int LEVEL_SHIFT  = 10;

  localparam int ACC_W        = 64;
  localparam int FRAC_BITS    = 8;
  localparam int QUOT_W       = 17;

  // One beat passed from the front half to the back half.
  typedef struct packed {
    logic             keep;
    logic [ACC_W-1:0] u;
    logic [ACC_W-1:0] v;
    logic [ACC_W-1:0] w;
    logic [16:0]      depth;
    logic [7:0]       red;
    logic [7:0]       green;
  } item_t;

endpackage

/* src/lpp_if.sv */
// Valid/ready channels for lidar points and projected results.
interface lpp_point_if #(
  parameter int COORD_WIDTH = 16
);
  logic                   valid;
  logic                   ready;
  logic [COORD_WIDTH-1:0] point_x;
  logic [COORD_WIDTH-1:0] point_y;
  logic [COORD_WIDTH-1:0] point_z;
  logic [15:0]            reflectance;

  modport source(output valid, point_x, point_y, point_z, reflectance, input ready);
  modport sink(input valid, point_x, point_y, point_z, reflectance, output ready);
endinterface

interface lpp_result_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic [15:0] pixel_column;
  logic [15:0] pixel_row;
  logic [16:0] depth_intensity;
  logic [7:0]  red_level;
  logic [7:0]  green_level;

  modport source(output valid, accepted, pixel_column, pixel_row, depth_intensity,
                 red_level, green_level, input ready);
  modport sink(input valid, accepted, pixel_column, pixel_row, depth_intensity,
               red_level, green_level, output ready);
endinterface

/* src/lpp_front.sv */
// Front half: filter, matrix products and row sums, three elastic stages.
module lpp_front
  import lpp_pkg::*;
#(
  parameter int COORD_WIDTH = 16,
  parameter int COEF_WIDTH  = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [11:0][COEF_WIDTH-1:0] coef,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [COORD_WIDTH-1:0]     in_x,
  input  logic [COORD_WIDTH-1:0]     in_y,
  input  logic [COORD_WIDTH-1:0]     in_z,
  input  logic [15:0]                in_refl,
  output logic                       out_valid,
  input  logic                       out_ready,
  output item_t                      out_item
);

  localparam int PROD_W = COEF_WIDTH + COORD_WIDTH;

  // Stage 1 holds the point, the filter verdict and |x-20|.
  logic                   s1_v;
  logic [COORD_WIDTH-1:0] s1_x, s1_y, s1_z;
  logic                   s1_keep;
  logic [DIFF_W-1:0]      s1_diff;

  // Stage 2 holds the nine products and the color values.
  logic                   s2_v;
  logic [ACC_W-1:0]       s2_prod [9];
  logic [ACC_W-1:0]       s2_const [3];
  logic                   s2_keep;
  logic [16:0]            s2_depth;
  logic [7:0]             s2_red, s2_green;

  // Stage 3 is the beat toward the queue.
  logic                   s3_v;
  item_t                  s3_item;

  logic adv1, adv2, adv3;

  // A stage loads when it is empty or its content moves on.
  assign adv3     = !s3_v || out_ready;
  assign adv2     = !s2_v || adv3;
  assign adv1     = !s1_v || adv2;
  assign in_ready = adv1;

  // Filter and distance to the mid range, on sign-extended coordinates.
  logic signed [32:0] ex, ey, ez, dx;
  logic               keep_c;
  logic [32:0]        dmag;
  always_comb begin
    ex     = 33'($signed(in_x));
    ey     = 33'($signed(in_y));
    ez     = 33'($signed(in_z));
    keep_c = (ex >= 0) && (ex <= 33'(X_MAX_RAW)) && (ey >= -33'(Y_MAX_RAW)) &&
             (ey <= 33'(Y_MAX_RAW)) && (ez >= 33'(Z_MIN_RAW)) &&
             (in_refl >= 16'(REFL_MIN_RAW));
    dx     = ex - 33'(MID_RAW);
    dmag   = dx[32] ? 33'(-dx) : 33'(dx);
  end

  // Products of the matrix with the point, sign-extended to the accumulator.
  logic signed [PROD_W-1:0]     prod_c [9];
  logic signed [COEF_WIDTH-1:0] cc;
  logic signed [ACC_W-1:0]      ce;
  logic [ACC_W-1:0]             const_c [3];
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      prod_c[r*3+0] = $signed(coef[r*4+0]) * $signed(s1_x);
      prod_c[r*3+1] = $signed(coef[r*4+1]) * $signed(s1_y);
      prod_c[r*3+2] = $signed(coef[r*4+2]) * $signed(s1_z);
    end
    cc = '0;
    ce = '0;
    for (int r = 0; r < 3; r++) begin
      cc         = $signed(coef[r*4+3]);
      ce         = ACC_W'(cc);
      const_c[r] = ACC_W'(ce) << FRAC_BITS;
    end
  end

  // Color products.
  logic [34:0]       depth_p;
  logic [17:0]       red_p, green_p;
  logic [DIFF_W-1:0] gdiff;
  always_comb begin
    depth_p = 35'(s1_diff) * 35'(DEPTH_MUL);
    red_p   = 18'(s1_diff) * 18'(LEVEL_MUL);
    gdiff   = (s1_diff >= DIFF_W'(MID_RAW)) ? '0 : DIFF_W'(DIFF_W'(MID_RAW) - s1_diff);
    green_p = 18'(gdiff) * 18'(LEVEL_MUL);
  end

  // Control of the three stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
    end else begin
      if (adv1) s1_v <= in_valid;
      if (adv2) s2_v <= s1_v;
      if (adv3) s3_v <= s2_v;
    end
  end

  // Payload of the three stages.
  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_x    <= in_x;
      s1_y    <= in_y;
      s1_z    <= in_z;
      s1_keep <= keep_c;
      s1_diff <= dmag[DIFF_W-1:0];
    end
    if (adv2) begin
      for (int i = 0; i < 9; i++) s2_prod[i] <= ACC_W'(prod_c[i]);
      for (int r = 0; r < 3; r++) s2_const[r] <= const_c[r];
      s2_keep  <= s1_keep;
      s2_depth <= depth_p[DEPTH_SHIFT+16:DEPTH_SHIFT];
      s2_red   <= red_p[LEVEL_SHIFT+7:LEVEL_SHIFT];
      s2_green <= green_p[LEVEL_SHIFT+7:LEVEL_SHIFT];
    end
    if (adv3) begin
      s3_item.keep  <= s2_keep;
      s3_item.u     <= s2_prod[0] + s2_prod[1] + s2_prod[2] + s2_const[0];
      s3_item.v     <= s2_prod[3] + s2_prod[4] + s2_prod[5] + s2_const[1];
      s3_item.w     <= s2_prod[6] + s2_prod[7] + s2_prod[8] + s2_const[2];
      s3_item.depth <= s2_depth;
      s3_item.red   <= s2_red;
      s3_item.green <= s2_green;
    end
  end

  assign out_valid = s3_v;
  assign out_item  = s3_item;

endmodule

/* src/lpp_queue.sv */
// Four-entry queue that decouples the front and back halves.
module lpp_queue
  import lpp_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  output logic  out_valid,
  input  logic  out_ready,
  output item_t out_item
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  item_t            slots [DEPTH];
  logic [PTR_W-1:0] wptr, rptr;
  logic [PTR_W:0]   count;
  logic             push, pop;

  assign in_ready  = (count != (PTR_W+1)'(DEPTH));
  assign out_valid = (count != '0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_item  = slots[rptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      count <= count + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= in_item;
  end

endmodule

/* src/lpp_back.sv */
// Back half: pipelined division of u and v by w, saturation and result register.
module lpp_back
  import lpp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  item_t       in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_accepted,
  output logic [15:0] out_column,
  output logic [15:0] out_row,
  output logic [16:0] out_depth,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green
);

  localparam int NITER = QUOT_W;
  localparam int WIDE  = ACC_W + QUOT_W;

  typedef struct packed {
    logic              ok;
    logic              neg_u;
    logic              neg_v;
    logic              sat_u;
    logic              sat_v;
    logic [ACC_W-1:0]  num_u;
    logic [ACC_W-1:0]  num_v;
    logic [ACC_W-1:0]  den;
    logic [QUOT_W-1:0] q_u;
    logic [QUOT_W-1:0] q_v;
    logic [16:0]       depth;
    logic [7:0]        red;
    logic [7:0]        green;
  } div_t;

  // One restoring step for quotient bit k of both divisions.
  function automatic div_t div_step(div_t s, int k);
    logic [WIDE-1:0] dsh;
    div_t            r;
    dsh = {{QUOT_W{1'b0}}, s.den} << k;
    r   = s;
    if ({{QUOT_W{1'b0}}, s.num_u} >= dsh) begin
      r.num_u    = s.num_u - dsh[ACC_W-1:0];
      r.q_u[k]   = 1'b1;
    end
    if ({{QUOT_W{1'b0}}, s.num_v} >= dsh) begin
      r.num_v    = s.num_v - dsh[ACC_W-1:0];
      r.q_v[k]   = 1'b1;
    end
    return r;
  endfunction

  // Signed 16-bit result from magnitude quotient, sign and overflow flag.
  function automatic logic [15:0] sat16(logic neg, logic sat, logic [QUOT_W-1:0] q);
    logic [QUOT_W-1:0] nq;
    nq = QUOT_W'(~q + 1'b1);
    if (neg) return (sat || q > QUOT_W'(32768)) ? 16'h8000 : nq[15:0];
    return (sat || q > QUOT_W'(32767)) ? 16'h7fff : q[15:0];
  endfunction

  div_t a_r, b_r;
  div_t it_r [NITER];
  div_t it_n [NITER];
  logic a_v, b_v, o_v;
  logic it_v [NITER];
  logic adv_a, adv_b, adv_o;
  logic adv_it [NITER];

  // Ready runs back from the result register through every stage.
  always_comb begin
    adv_o = !o_v || out_ready;
    adv_it[NITER-1] = !it_v[NITER-1] || adv_o;
    for (int j = NITER - 2; j >= 0; j--) adv_it[j] = !it_v[j] || adv_it[j+1];
    adv_b = !b_v || adv_it[0];
    adv_a = !a_v || adv_b;
  end
  assign in_ready = adv_a;

  // Magnitudes, quotient signs and the zero-divisor test.
  logic [ACC_W-1:0] mu, mv, mw;
  div_t             a_n, b_n;
  always_comb begin
    mu = in_item.u[ACC_W-1] ? ACC_W'(-in_item.u) : in_item.u;
    mv = in_item.v[ACC_W-1] ? ACC_W'(-in_item.v) : in_item.v;
    mw = in_item.w[ACC_W-1] ? ACC_W'(-in_item.w) : in_item.w;
    a_n       = '0;
    a_n.ok    = in_item.keep && (in_item.w != '0);
    a_n.neg_u = in_item.u[ACC_W-1] ^ in_item.w[ACC_W-1];
    a_n.neg_v = in_item.v[ACC_W-1] ^ in_item.w[ACC_W-1];
    a_n.num_u = mu;
    a_n.num_v = mv;
    a_n.den   = mw;
    a_n.depth = in_item.depth;
    a_n.red   = in_item.red;
    a_n.green = in_item.green;
    // A quotient that needs more than QUOT_W bits saturates.
    b_n       = a_r;
    b_n.sat_u = {{QUOT_W{1'b0}}, a_r.num_u} >= {a_r.den, {QUOT_W{1'b0}}};
    b_n.sat_v = {{QUOT_W{1'b0}}, a_r.num_v} >= {a_r.den, {QUOT_W{1'b0}}};
  end

  // Each iteration stage settles one quotient bit, most significant first.
  always_comb begin
    it_n[0] = div_step(b_r, NITER - 1);
    for (int j = 1; j < NITER; j++) it_n[j] = div_step(it_r[j-1], NITER - 1 - j);
  end

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
      b_v <= 1'b0;
      o_v <= 1'b0;
      for (int j = 0; j < NITER; j++) it_v[j] <= 1'b0;
    end else begin
      if (adv_a) a_v <= in_valid;
      if (adv_b) b_v <= a_v;
      if (adv_it[0]) it_v[0] <= b_v;
      for (int j = 1; j < NITER; j++) begin
        if (adv_it[j]) it_v[j] <= it_v[j-1];
      end
      if (adv_o) o_v <= it_v[NITER-1];
    end
  end

  // Stage payloads and the result register; a dropped point reads all zero.
  always_ff @(posedge clk) begin
    if (adv_a) a_r <= a_n;
    if (adv_b) b_r <= b_n;
    for (int j = 0; j < NITER; j++) begin
      if (adv_it[j]) it_r[j] <= it_n[j];
    end
    if (adv_o) begin
      if (it_r[NITER-1].ok) begin
        out_accepted <= 1'b1;
        out_column   <= sat16(it_r[NITER-1].neg_u, it_r[NITER-1].sat_u, it_r[NITER-1].q_u);
        out_row      <= sat16(it_r[NITER-1].neg_v, it_r[NITER-1].sat_v, it_r[NITER-1].q_v);
        out_depth    <= it_r[NITER-1].depth;
        out_red      <= it_r[NITER-1].red;
        out_green    <= it_r[NITER-1].green;
      end else begin
        out_accepted <= 1'b0;
        out_column   <= '0;
        out_row      <= '0;
        out_depth    <= '0;
        out_red      <= '0;
        out_green    <= '0;
      end
    end
  end

  assign out_valid = o_v;

endmodule

/* src/lidar_point_projection.sv */
// Top level of the lidar point projection block: register file and the two halves.
//
// Usage: lidar points enter on the points channel, one beat per point, and one
// result beat leaves on the results channel for every point, in order. The
// projection matrix is written through the APB port, six 64-bit registers at
// byte addresses 0, 8, ..., 40, each holding two Q16.16 coefficients (even
// column in bits 31..0). Write the matrix only while no point is in flight.
// Points are taken one per cycle while the results channel does not stall. On the
// way from an accepted point beat to its result beat lie three front stages (filter,
// multiply, sum), one queue slot, and twenty back stages, of which seventeen
// each settle one quotient bit of the restoring divider.
// A four-entry queue sits between the halves. When the receiver stalls, the
// back pipeline fills, then the queue, then the front, and only then does
// points.ready drop; no beat is lost. Reset clears all matrix registers to
// zero and empties every stage and the queue.
module lidar_point_projection
  import lpp_pkg::*;
#(
  parameter int COORD_WIDTH = 16,
  parameter int COEF_WIDTH  = 32
) (
  input  logic               clk,
  input  logic               rst,
  lpp_point_if.sink          points,
  lpp_result_if.source       results,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);

  logic [63:0]                matrix [NUM_REGS];
  logic [REG_IDX_W-1:0]       reg_idx;
  logic [11:0][COEF_WIDTH-1:0] coef;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:3];

  // Matrix registers; writes beyond the last register are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) matrix[i] <= '0;
    end else if (psel && penable && pwrite && pready &&
                 reg_idx < REG_IDX_W'(NUM_REGS)) begin
      matrix[reg_idx] <= pwdata;
    end
  end

  // Register readback.
  always_comb begin
    prdata = '0;
    if (reg_idx < REG_IDX_W'(NUM_REGS)) prdata = matrix[reg_idx];
  end

  // Unpack the coefficients: row r, column c at index r*4+c.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 4; c++) begin
        if (c % 2 == 1) coef[r*4+c] = matrix[r*2 + c/2][32 +: COEF_WIDTH];
        else            coef[r*4+c] = matrix[r*2 + c/2][0 +: COEF_WIDTH];
      end
    end
  end

  logic  f_valid, f_ready, q_valid, q_ready;
  item_t f_item, q_item;

  lpp_front #(
    .COORD_WIDTH(COORD_WIDTH),
    .COEF_WIDTH (COEF_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .coef     (coef),
    .in_valid (points.valid),
    .in_ready (points.ready),
    .in_x     (points.point_x),
    .in_y     (points.point_y),
    .in_z     (points.point_z),
    .in_refl  (points.reflectance),
    .out_valid(f_valid),
    .out_ready(f_ready),
    .out_item (f_item)
  );

  lpp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .in_valid (f_valid),
    .in_ready (f_ready),
    .in_item  (f_item),
    .out_valid(q_valid),
    .out_ready(q_ready),
    .out_item (q_item)
  );

  lpp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (q_valid),
    .in_ready    (q_ready),
    .in_item     (q_item),
    .out_valid   (results.valid),
    .out_ready   (results.ready),
    .out_accepted(results.accepted),
    .out_column  (results.pixel_column),
    .out_row     (results.pixel_row),
    .out_depth   (results.depth_intensity),
    .out_red     (results.red_level),
    .out_green   (results.green_level)
  );

  // A dropped point carries all-zero fields.
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    results.valid && !results.accepted |->
      results.pixel_column == 16'd0 && results.pixel_row == 16'd0 &&
      results.depth_intensity == 17'd0 && results.red_level == 8'd0 &&
      results.green_level == 8'd0)
    else $error("rejected result has nonzero fields");

  // Red and green split at most the full level between them.
  a_level_sum: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> (9'(results.red_level) + 9'(results.green_level)) <= 9'd255)
    else $error("red plus green exceeds full level");

  // Depth intensity never exceeds full scale.
  a_depth_cap: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> results.depth_intensity <= 17'd65536)
    else $error("depth intensity above full scale");

endmodule

/* verif/lpp_scoreboard.sv */
// Checker that predicts every result beat of the projection block and compares it.
module lpp_scoreboard
  import lpp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  lpp_point_if              points,
  lpp_result_if             results,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [63:0]       pwdata,
  output int                errors,
  output int                outstanding
);

  typedef struct {
    bit        accepted;
    bit [15:0] column;
    bit [15:0] row;
    bit [16:0] depth;
    bit [7:0]  red;
    bit [7:0]  green;
  } pixel_t;

  bit [63:0] matrix [NUM_REGS];
  pixel_t    pixels_due [$];

  // One Q16.16 coefficient of the composed projection matrix.
  function automatic longint coefficient(int r, int c);
    bit [63:0] word;
    bit [31:0] slot;
    word = matrix[r * 2 + c / 2];
    slot = (c % 2 == 1) ? word[63:32] : word[31:0];
    return longint'(int'(slot));
  endfunction

  // Q40.24 dot product of one matrix row with (x, y, z, 1), wrapping at 64 bits.
  function automatic longint project_row(int r, longint x, longint y, longint z);
    longint sum;
    sum = coefficient(r, 0) * x + coefficient(r, 1) * y + coefficient(r, 2) * z
          + (coefficient(r, 3) <<< FRAC_BITS);
    return sum;
  endfunction

  // Quotient of magnitudes with the sign applied, saturated to 16 bits.
  function automatic bit [15:0] pixel_quotient(longint num, longint den);
    bit [63:0] mag_n;
    bit [63:0] mag_d;
    bit [63:0] q;
    mag_n = (num < 0) ? 64'd0 - 64'(num) : 64'(num);
    mag_d = (den < 0) ? 64'd0 - 64'(den) : 64'(den);
    q = mag_n / mag_d;
    if ((num < 0) != (den < 0))
      return (q > 64'd32768) ? 16'h8000 : 16'(64'd0 - q);
    return (q > 64'd32767) ? 16'h7fff : q[15:0];
  endfunction

  function automatic pixel_t project_point(longint x, longint y, longint z, int refl);
    pixel_t p;
    longint u, v, w;
    longint diff;
    p = '{default: 0};
    if (x < 0 || x > X_MAX_RAW || y < -Y_MAX_RAW || y > Y_MAX_RAW ||
        z < Z_MIN_RAW || refl < REFL_MIN_RAW)
      return p;
    u = project_row(0, x, y, z);
    v = project_row(1, x, y, z);
    w = project_row(2, x, y, z);
    if (w == 0)
      return p;
    diff = (x >= MID_RAW) ? x - MID_RAW : MID_RAW - x;
    p.accepted = 1;
    p.column   = pixel_quotient(u, w);
    p.row      = pixel_quotient(v, w);
    p.depth    = ((diff * 65536) / MID_RAW > 65536) ? 17'd65536 : 17'((diff * 65536) / MID_RAW);
    p.red      = ((diff * 255) / MID_RAW > 255) ? 8'd255 : 8'((diff * 255) / MID_RAW);
    p.green    = (diff >= MID_RAW) ? 8'd0 : 8'(((MID_RAW - diff) * 255) / MID_RAW);
    return p;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  assign outstanding = pixels_due.size();

  // Track register writes, predict each point beat and check each result beat.
  always @(posedge clk) begin
    pixel_t seen;
    pixel_t want;
    pixel_t due;
    if (rst) begin
      foreach (matrix[i]) matrix[i] = '0;
      pixels_due.delete();
      errors = 0;
    end else begin
      if (psel && penable && pwrite && pready && (paddr / 8) < NUM_REGS)
        matrix[paddr / 8] = pwdata;
      if (points.valid && points.ready) begin
        due = project_point(longint'(signed'(points.point_x)),
                            longint'(signed'(points.point_y)),
                            longint'(signed'(points.point_z)),
                            int'(points.reflectance));
        pixels_due = {pixels_due, due};
      end
      if (results.valid && results.ready) begin
        seen = '{results.accepted, results.pixel_column, results.pixel_row,
                 results.depth_intensity, results.red_level, results.green_level};
        if (pixels_due.size() == 0) begin
          report_mismatch("unexpected result beat", 1, 0);
        end else begin
          want = pixels_due.pop_front();
          if (seen.accepted != want.accepted)
            report_mismatch("accepted", seen.accepted, want.accepted);
          if (seen.column != want.column)
            report_mismatch("pixel_column", seen.column, want.column);
          if (seen.row != want.row) report_mismatch("pixel_row", seen.row, want.row);
          if (seen.depth != want.depth)
            report_mismatch("depth_intensity", seen.depth, want.depth);
          if (seen.red != want.red) report_mismatch("red_level", seen.red, want.red);
          if (seen.green != want.green)
            report_mismatch("green_level", seen.green, want.green);
        end
      end
    end
  end

endmodule

/* verif/lidar_point_projection_test.sv */
// Stimulus, clocking and verdict for the lidar point projection block.
module lidar_point_projection_test;
  import lpp_pkg::*;

  localparam int REG_STRIDE   = 8;
  localparam int STALL_LIMIT  = 20000;
  localparam int DRAIN_CYCLES = 40;
  localparam int ONE_Q16      = 32'h0001_0000;

  typedef enum int { MATRIX_ZERO, MATRIX_PINHOLE, MATRIX_RANDOM, MATRIX_EXTREME } matrix_kind_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;
  int          errors;
  int          outstanding;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_cycles = 0;
  int          quiet_cycles = 0;

  lpp_point_if  points ();
  lpp_result_if results ();

  initial begin
    points.valid = 0;
    points.point_x = '0;
    points.point_y = '0;
    points.point_z = '0;
    points.reflectance = '0;
    results.ready = 0;
  end

  lidar_point_projection DUT (
    .clk, .rst, .points(points.sink), .results(results.source),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  lpp_scoreboard checker_inst (
    .clk, .rst, .points, .results, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .errors, .outstanding
  );

  always #5 clk = ~clk;

  // Receiver: random stalls, plus long hold-offs on request.
  always @(posedge clk) begin
    if (rst) begin
      results.ready <= 0;
    end else if (hold_cycles > 0) begin
      results.ready <= 0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      results.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog on cycles in which no beat moves on any port.
  always @(posedge clk) begin
    if ((points.valid && points.ready) || (results.valid && results.ready) || psel)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic write_register(int index, logic [63:0] value);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= ADDR_W'(index * REG_STRIDE); pwdata <= value;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  function automatic logic [31:0] extreme_coef();
    case ($urandom_range(3))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'hffff_ffff;
      default: return 32'h0000_0001;
    endcase
  endfunction

  // Load the six matrix registers; the two unused addresses are written too.
  task automatic load_matrix(matrix_kind_t kind);
    logic [31:0] c [12];
    foreach (c[i]) c[i] = '0;
    case (kind)
      MATRIX_PINHOLE: begin
        // u = 700*(-y) + 320*x, v = 700*(-z) + 240*x plus a random constant of at most 5, w = x.
        c[0] = 32'(320 * ONE_Q16); c[1] = -32'(700 * ONE_Q16);
        c[4] = 32'(240 * ONE_Q16); c[6] = -32'(700 * ONE_Q16);
        c[7] = 32'($urandom_range(ONE_Q16 * 5));
        c[8] = ONE_Q16;
      end
      MATRIX_RANDOM: begin
        foreach (c[i]) c[i] = ($urandom_range(3) == 0) ? $urandom
                              : 32'(int'($urandom_range(2 * ONE_Q16)) - ONE_Q16);
      end
      MATRIX_EXTREME: begin
        foreach (c[i]) c[i] = extreme_coef();
      end
      default: ;
    endcase
    // Registers hold two coefficients: even column in the low half.
    for (int r = 0; r < 3; r++) begin
      write_register(r * 2,     {c[r * 4 + 1], c[r * 4]});
      write_register(r * 2 + 1, {c[r * 4 + 3], c[r * 4 + 2]});
    end
    write_register(NUM_REGS, {$urandom, $urandom});
    write_register(NUM_REGS + 1, {$urandom, $urandom});
  endtask

  // Offer one point beat, idling at random first, and wait until it is taken.
  task automatic send_point(int x, int y, int z, int refl);
    while ($urandom_range(99) < send_idle_pct) begin
      points.valid <= 0;
      @(posedge clk);
    end
    points.valid <= 1;
    points.point_x <= 16'(x);
    points.point_y <= 16'(y);
    points.point_z <= 16'(z);
    points.reflectance <= 16'(refl);
    do @(posedge clk); while (!points.ready);
  endtask

  task automatic send_random_point();
    if ($urandom_range(3) == 0)
      send_point($urandom, $urandom, $urandom, $urandom);
    else
      send_point($urandom_range(X_MAX_RAW), int'($urandom_range(2 * Y_MAX_RAW)) - Y_MAX_RAW,
                 ($urandom_range(7) == 0) ? int'($urandom_range(32767))
                                          : int'($urandom_range(1200)) + Z_MIN_RAW,
                 $urandom_range(65535, REFL_MIN_RAW));
  endtask

  // Pause the sender until every result has come, then let the pipe settle.
  task automatic drain();
    points.valid <= 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_directed();
    send_point(0, 0, 0, REFL_MIN_RAW);
    send_point(X_MAX_RAW, Y_MAX_RAW, Z_MIN_RAW, 65535);
    send_point(X_MAX_RAW + 1, 0, 0, 65535);
    send_point(-1, 0, 0, 65535);
    send_point(MID_RAW, -Y_MAX_RAW, 0, 40000);
    send_point(MID_RAW, Y_MAX_RAW + 1, 0, 40000);
    send_point(MID_RAW, -Y_MAX_RAW - 1, 0, 40000);
    send_point(2560, 100, Z_MIN_RAW - 1, 40000);
    send_point(2560, 100, 32767, 40000);
    send_point(2560, 100, -32768, 40000);
    send_point(2560, 100, 50, REFL_MIN_RAW - 1);
    send_point(2560, 100, 50, 0);
    send_point(32767, 32767, 32767, 65535);
    send_point(-32768, -32768, -32768, 0);
    send_point(1, -1, -1, REFL_MIN_RAW);
    send_point(MID_RAW - 1, 1, 1, 1000);
    send_point(MID_RAW + 1, 1, 1, 1000);
  endtask

  initial begin
    matrix_kind_t kinds [6];
    kinds = '{MATRIX_ZERO, MATRIX_PINHOLE, MATRIX_RANDOM, MATRIX_EXTREME, MATRIX_PINHOLE,
              MATRIX_RANDOM};
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    for (int phase = 0; phase < 6; phase++) begin
      if (phase < 2) begin
        send_idle_pct = 30; recv_stall_pct = 55;
      end else if (phase < 4) begin
        send_idle_pct = 55; recv_stall_pct = 30;
      end else begin
        send_idle_pct = 0; recv_stall_pct = 0;
      end
      load_matrix(kinds[phase]);
      if (phase == 4) hold_cycles = 300;
      if (phase <= 1 || phase == 3) send_directed();
      repeat (130) send_random_point();
      drain();
    end
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
